>>> design/mpct_pkg.sv
// ============================================================================
// mpct_pkg: shared types and constants for the mouse packet cursor tracker
// Holds the register indexes, reset values, byte bit positions and the decoded packet structure.
// ============================================================================
package mpct_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned POS_W     = 12;
	localparam int unsigned MOVE_W    = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURSOR_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURSOR_Y = 4'd1;

	localparam logic [POS_W-1:0] MAX_X_RESET = 12'd1152;
	localparam logic [POS_W-1:0] MAX_Y_RESET = 12'd864;

	// Bit positions inside the first byte of a packet.
	localparam int unsigned BIT_LEFT   = 0;
	localparam int unsigned BIT_RIGHT  = 1;
	localparam int unsigned BIT_MIDDLE = 2;
	localparam int unsigned BIT_SYNC   = 3;
	localparam int unsigned BIT_XSIGN  = 4;
	localparam int unsigned BIT_YSIGN  = 5;
	localparam int unsigned BIT_XOVF   = 6;
	localparam int unsigned BIT_YOVF   = 7;

	typedef enum logic [2:0] {
		BYTE_FIRST  = 3'b001,
		BYTE_SECOND = 3'b010,
		BYTE_THIRD  = 3'b100
	} byte_pos_t;

	typedef struct packed {
		logic                     done;
		logic                     left_button;
		logic                     right_button;
		logic                     middle_button;
		logic                     x_overflow;
		logic                     y_overflow;
		logic signed [MOVE_W-1:0] move_x;
		logic signed [MOVE_W-1:0] move_y;
	} pkt_t;

endpackage

>>> design/mpct_framer.sv
// ============================================================================
// mpct_framer: packet framing for the three-byte mouse stream
// Tracks the byte position, holds the first two bytes and decodes a packet
// when the third byte is presented.
// ============================================================================
module mpct_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_fire,
	input  logic [7:0]          byte_data,
	output mpct_pkg::pkt_t      pkt
);
	import mpct_pkg::*;

	byte_pos_t  pos_q;
	byte_pos_t  pos_next;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       take_first;
	logic       take_second;

	always_comb begin
		pos_next    = pos_q;
		take_first  = 1'b0;
		take_second = 1'b0;
		pkt         = '0;
		case (pos_q)
			BYTE_SECOND: begin
				take_second = 1'b1;
				pos_next    = BYTE_THIRD;
			end
			BYTE_THIRD: begin
				pos_next          = BYTE_FIRST;
				pkt.done          = byte_valid;
				pkt.left_button   = first_q[BIT_LEFT];
				pkt.right_button  = first_q[BIT_RIGHT];
				pkt.middle_button = first_q[BIT_MIDDLE];
				pkt.x_overflow    = first_q[BIT_XOVF];
				pkt.y_overflow    = first_q[BIT_YOVF];
				pkt.move_x        = {first_q[BIT_XSIGN], second_q};
				pkt.move_y        = {first_q[BIT_YSIGN], byte_data};
			end
			default: begin
				// A first byte without the sync bit is dropped to regain alignment.
				if (byte_data[BIT_SYNC]) begin
					take_first = 1'b1;
					pos_next   = BYTE_SECOND;
				end else begin
					pos_next = BYTE_FIRST;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= BYTE_FIRST;
		end else if (byte_fire) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && take_first) begin
			first_q <= byte_data;
		end
		if (byte_fire && take_second) begin
			second_q <= byte_data;
		end
	end

endmodule

>>> design/mpct_cursor.sv
// ============================================================================
// mpct_cursor: clamped cursor position tracking
// Applies a packet's deltas to the cursor and clamps each axis to its limit.
// ============================================================================
module mpct_cursor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              update,
	input  logic signed [mpct_pkg::MOVE_W-1:0] move_x,
	input  logic signed [mpct_pkg::MOVE_W-1:0] move_y,
	input  logic [mpct_pkg::POS_W-1:0]        max_x,
	input  logic [mpct_pkg::POS_W-1:0]        max_y,
	output logic [mpct_pkg::POS_W-1:0]        next_x,
	output logic [mpct_pkg::POS_W-1:0]        next_y
);
	import mpct_pkg::*;

	localparam int unsigned SUM_W = POS_W + 2;

	logic [POS_W-1:0]        cursor_x_q;
	logic [POS_W-1:0]        cursor_y_q;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;

	function automatic logic [POS_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
			input logic [POS_W-1:0] lim);
		logic [POS_W-1:0] res;
		if (v[SUM_W-1]) begin
			res = '0;
		end else if (v[SUM_W-2:0] > {1'b0, lim}) begin
			res = lim;
		end else begin
			res = v[POS_W-1:0];
		end
		return res;
	endfunction

	// Y is subtracted because the screen axis grows downward.
	assign sum_x = $signed({2'b00, cursor_x_q}) + SUM_W'(move_x);
	assign sum_y = $signed({2'b00, cursor_y_q}) - SUM_W'(move_y);

	assign next_x = clamp(sum_x, max_x);
	assign next_y = clamp(sum_y, max_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (update) begin
			cursor_x_q <= next_x;
			cursor_y_q <= next_y;
		end
	end

endmodule

>>> design/mouse_packet_cursor_tracker_top.sv
// ============================================================================
// mouse_packet_cursor_tracker_top: mouse packet decoder with cursor tracking
// Input register, framing and cursor logic, and a result register.
// ============================================================================
// Takes one raw mouse byte per cycle while in_stall is low and emits one
// word per complete three-byte packet; the third byte passes through the
// input register and then the result register. A first byte without
// bit 3 set is dropped. The cursor adds move_x and subtracts move_y and is
// clamped to 0..max_cursor_x and 0..max_cursor_y; the overflow bits are only
// reported. Bytes that complete no packet never wait on the output side;
// only a third byte stalls while an unclaimed result still holds the result
// register. Configuration writes are always ready and should be issued while
// no packet is in flight.
module mouse_packet_cursor_tracker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpct_pkg::POS_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               left_button,
	output logic                               right_button,
	output logic                               middle_button,
	output logic                               x_overflow,
	output logic                               y_overflow,
	output logic signed [mpct_pkg::MOVE_W-1:0] move_x,
	output logic signed [mpct_pkg::MOVE_W-1:0] move_y,
	output logic [mpct_pkg::POS_W-1:0]         pos_x,
	output logic [mpct_pkg::POS_W-1:0]         pos_y
);
	import mpct_pkg::*;

	logic [POS_W-1:0] max_x_q;
	logic [POS_W-1:0] max_y_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             fire_s1;
	logic             in_fire;
	pkt_t             pkt;
	logic [POS_W-1:0] next_x;
	logic [POS_W-1:0] next_y;
	logic             result_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MAX_CURSOR_X) begin
				max_x_q <= cfg_data;
			end else if (cfg_index == CFG_MAX_CURSOR_Y) begin
				max_y_q <= cfg_data;
			end
		end
	end

	// The staged byte moves on unless it completes a packet and the result
	// register is still held by an unclaimed word.
	assign out_free    = !out_valid || !out_stall;
	assign fire_s1     = valid_s1 && (!pkt.done || out_free);
	assign result_fire = fire_s1 && pkt.done;
	assign in_stall    = valid_s1 && !fire_s1;
	assign in_fire     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || fire_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= rx_byte;
		end
	end

	mpct_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (valid_s1),
		.byte_fire  (fire_s1),
		.byte_data  (byte_s1),
		.pkt        (pkt)
	);

	mpct_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.update (result_fire),
		.move_x (pkt.move_x),
		.move_y (pkt.move_y),
		.max_x  (max_x_q),
		.max_y  (max_y_q),
		.next_x (next_x),
		.next_y (next_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= result_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (result_fire) begin
			left_button   <= pkt.left_button;
			right_button  <= pkt.right_button;
			middle_button <= pkt.middle_button;
			x_overflow    <= pkt.x_overflow;
			y_overflow    <= pkt.y_overflow;
			move_x        <= pkt.move_x;
			move_y        <= pkt.move_y;
			pos_x         <= next_x;
			pos_y         <= next_y;
		end
	end

endmodule

>>> dv/mouse_tracker_monitor.sv
// ============================================================================
// mouse_tracker_monitor: prediction and comparison for the cursor tracker
// Watches the configuration, byte and packet channels, decodes the byte
// stream on its own, and compares every packet word with its prediction.
// ============================================================================
`timescale 1ns / 1ps

module mouse_tracker_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [mpct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpct_pkg::POS_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [7:0]                         rx_byte,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               left_button,
	input  logic                               right_button,
	input  logic                               middle_button,
	input  logic                               x_overflow,
	input  logic                               y_overflow,
	input  logic signed [mpct_pkg::MOVE_W-1:0] move_x,
	input  logic signed [mpct_pkg::MOVE_W-1:0] move_y,
	input  logic [mpct_pkg::POS_W-1:0]         pos_x,
	input  logic [mpct_pkg::POS_W-1:0]         pos_y,
	output int                                 mismatches,
	output int                                 outstanding
);

	import mpct_pkg::*;

	typedef struct packed {
		logic                     left;
		logic                     right;
		logic                     middle;
		logic                     xovf;
		logic                     yovf;
		logic signed [MOVE_W-1:0] dx;
		logic signed [MOVE_W-1:0] dy;
		logic [POS_W-1:0]         px;
		logic [POS_W-1:0]         py;
	} cursor_report_t;

	cursor_report_t   packet_q[$];
	byte_pos_t        framing;
	logic [7:0]       head_byte;
	logic [7:0]       x_byte;
	logic [POS_W-1:0] cur_x;
	logic [POS_W-1:0] cur_y;
	logic [POS_W-1:0] lim_x;
	logic [POS_W-1:0] lim_y;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	function automatic logic [POS_W-1:0] clamp_axis(input int v, input logic [POS_W-1:0] hi);
		if (v < 0)
			return '0;
		if (v > int'(hi))
			return hi;
		return POS_W'(v);
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		cursor_report_t r;
		int dx;
		int dy;
		case (framing)
			BYTE_SECOND: begin
				x_byte = b;
				framing = BYTE_THIRD;
			end
			BYTE_THIRD: begin
				// The sign bits live in the first byte, the magnitudes in the others.
				dx = head_byte[BIT_XSIGN] ? int'(x_byte) - 256 : int'(x_byte);
				dy = head_byte[BIT_YSIGN] ? int'(b) - 256 : int'(b);
				cur_x = clamp_axis(int'(cur_x) + dx, lim_x);
				cur_y = clamp_axis(int'(cur_y) - dy, lim_y);
				r.left   = head_byte[BIT_LEFT];
				r.right  = head_byte[BIT_RIGHT];
				r.middle = head_byte[BIT_MIDDLE];
				r.xovf   = head_byte[BIT_XOVF];
				r.yovf   = head_byte[BIT_YOVF];
				r.dx     = MOVE_W'(dx);
				r.dy     = MOVE_W'(dy);
				r.px     = cur_x;
				r.py     = cur_y;
				packet_q.push_back(r);
				framing = BYTE_FIRST;
			end
			default: begin
				// Only a byte with the sync bit set can open a packet.
				if (b[BIT_SYNC]) begin
					head_byte = b;
					framing = BYTE_SECOND;
				end else begin
					framing = BYTE_FIRST;
				end
			end
		endcase
	endtask

	task automatic compare_word();
		cursor_report_t want;
		if (packet_q.size() == 0) begin
			report_mismatch($sformatf("word with no packet pending (pos %0d,%0d)",
				pos_x, pos_y));
			return;
		end
		want = packet_q.pop_front();
		check_field("left_button", int'(left_button), int'(want.left));
		check_field("right_button", int'(right_button), int'(want.right));
		check_field("middle_button", int'(middle_button), int'(want.middle));
		check_field("x_overflow", int'(x_overflow), int'(want.xovf));
		check_field("y_overflow", int'(y_overflow), int'(want.yovf));
		check_field("move_x", int'(move_x), int'(want.dx));
		check_field("move_y", int'(move_y), int'(want.dy));
		check_field("pos_x", int'(pos_x), int'(want.px));
		check_field("pos_y", int'(pos_y), int'(want.py));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x = MAX_X_RESET;
			lim_y = MAX_Y_RESET;
			framing = BYTE_FIRST;
			head_byte = '0;
			x_byte = '0;
			cur_x = '0;
			cur_y = '0;
			packet_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_CURSOR_X: lim_x = cfg_data;
					CFG_MAX_CURSOR_Y: lim_y = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte(rx_byte);
			if (out_valid && !out_stall)
				compare_word();
			outstanding <= packet_q.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// ============================================================================
// tb_top: testbench for the mouse packet cursor tracker
// Drives directed and random byte streams under several cursor limits and
// idle patterns; the monitor predicts every packet word and counts mismatches.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

	import mpct_pkg::*;

	localparam int N_PHASES      = 8;
	localparam int PHASE_BYTES   = 160;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] SYNC_MASK = 8'(1 << BIT_SYNC);
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = '1;

	localparam int GAP_PCT [4]   = '{0, 86, 0, 13};
	localparam int STALL_PCT [4] = '{0, 0, 86, 13};

	// The first limits are lowered well below where the cursor was left.
	localparam logic [POS_W-1:0] LIMIT_X [N_PHASES] =
		'{12'd100, 12'd0, 12'hFFF, 12'hFFF, 12'd0, MAX_X_RESET, 12'd0, 12'd0};
	localparam logic [POS_W-1:0] LIMIT_Y [N_PHASES] =
		'{12'd50, 12'd0, 12'hFFF, 12'd0, 12'hFFF, MAX_Y_RESET, 12'd0, 12'd0};

	// Dropped bytes out of sync, then packets that hit the sign, button,
	// overflow and magnitude extremes and clamp against both cursor bounds.
	localparam logic [7:0] DIRECTED_BYTES [20] = '{
		8'h00, 8'hF7,
		8'h08, 8'h00, 8'h00,
		8'h0F, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF,
		8'h18, 8'h00, 8'h00,
		8'h28, 8'h7F, 8'h00,
		8'hC8, 8'h80, 8'h80
	};

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic left_button;
	logic right_button;
	logic middle_button;
	logic x_overflow;
	logic y_overflow;
	logic signed [MOVE_W-1:0] move_x;
	logic signed [MOVE_W-1:0] move_y;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;

	int mismatches;
	int outstanding;
	int gap_pct = 0;
	int stall_pct = 0;

	mouse_packet_cursor_tracker_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_button   (left_button),
		.right_button  (right_button),
		.middle_button (middle_button),
		.x_overflow    (x_overflow),
		.y_overflow    (y_overflow),
		.move_x        (move_x),
		.move_y        (move_y),
		.pos_x         (pos_x),
		.pos_y         (pos_y)
	);

	mouse_tracker_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_button   (left_button),
		.right_button  (right_button),
		.middle_button (middle_button),
		.x_overflow    (x_overflow),
		.y_overflow    (y_overflow),
		.move_x        (move_x),
		.move_y        (move_y),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Valid stays high after an accepted byte so that back-to-back bytes
	// never see valid lowered and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// A write to an unused index follows the real ones and must change nothing.
	task automatic configure(input logic [POS_W-1:0] lx, input logic [POS_W-1:0] ly,
		input logic [CFG_IDX_W-1:0] stray);
		write_reg(CFG_MAX_CURSOR_X, lx);
		write_reg(CFG_MAX_CURSOR_Y, ly);
		write_reg(stray, POS_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed packets with random content; the odd stray byte
	// knocks the framing out of step and the sync check has to recover.
	task automatic run_traffic(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(9) == 0) begin
				send_byte(8'($urandom));
				sent++;
			end else begin
				send_byte(8'($urandom) | SYNC_MASK);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
				sent += 3;
			end
		end
	endtask

	initial begin
		logic [POS_W-1:0] lx;
		logic [POS_W-1:0] ly;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(12'hFFF, 12'hFFF, CFG_TOP_IDX);
		foreach (DIRECTED_BYTES[k])
			send_byte(DIRECTED_BYTES[k]);
		settle();

		for (int i = 0; i < N_PHASES; i++) begin
			lx = LIMIT_X[i];
			ly = LIMIT_Y[i];
			if (i >= N_PHASES - 2) begin
				lx = POS_W'($urandom);
				ly = POS_W'($urandom);
			end
			configure(lx, ly, CFG_IDX_W'($urandom_range(CFG_MAX_CURSOR_Y + 1, CFG_TOP_IDX)));
			gap_pct = GAP_PCT[i % 4];
			stall_pct = STALL_PCT[i % 4];
			run_traffic(PHASE_BYTES);
			settle();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
design/mpct_pkg.sv
design/mpct_framer.sv
design/mpct_cursor.sv
design/mouse_packet_cursor_tracker_top.sv
dv/mouse_tracker_monitor.sv
dv/tb_top.sv
